@@ rtl/core/tisa_pkg.sv @@
`timescale 1ns / 1ps

package tisa_pkg;

  // table geometry
  localparam int unsigned SLOTS   = 64;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned KEY_W   = 31;
  localparam int unsigned PTR_W   = 8;

  // register file
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] COUNT_MAX = (SLOTS > 127) ? 7'd127 : CFG_W'(SLOTS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT = 1'b0,
    REG_SLOT_BASE  = 1'b1
  } cfg_reg_e;

  // request kinds
  typedef enum logic [1:0] {
    REQ_ASSIGN = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // stream word widths
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_ALLOC  = 7'b0001000,
    ST_PROBE  = 7'b0010000,
    ST_WRITE  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

endpackage

@@ rtl/core/track_id_slot_allocator.sv @@
`timescale 1ns / 1ps

// channel   | dir | handshake              | payload
// ----------+-----+------------------------+-----------------------------------------
// request   | in  | s_axis_tvalid/tready   | tdata: ext_id; tuser: req_type
// result    | out | m_axis_tvalid/tready   | tdata: slot_number; tuser: slot_valid,
//           |     |                        |   newly_assigned
// config    | in  | cfg_we_i (no stall)    | cfg_idx_i, cfg_data_i
//
// one request word at a time; ready only while the sequencer is idle
// steps per word: accept, key scan (one table read per cycle,
//   registered read port), decide, then for a new binding an alloc step,
//   pointer probes and a write, and last the hand-off of the result
// rejected ids and unknown kinds skip straight to the hand-off cycle
// the result sits in an output register, so a stalled result does not block
//   the next request; the sequencer only waits if a second result is ready
// reset clears all used bits, the pointer to base-1 and the wrapped flag;
//   a config write does the same

module track_id_slot_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tisa_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] ext_id
  input  logic [tisa_pkg::IN_USER_W-1:0]  s_axis_tuser,   // [1:0] req_type
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tisa_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] slot_number, [7:6] zero
  output logic [tisa_pkg::OUT_USER_W-1:0] m_axis_tuser,   // [0] slot_valid, [1] newly_assigned
  // config write port
  input  logic                            cfg_we_i,
  input  logic [tisa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tisa_pkg::CFG_W-1:0]      cfg_data_i
);
  import tisa_pkg::*;

  // config registers
  logic [CFG_W-1:0] slot_count_q;
  logic             slot_base_q;
  logic [CFG_W-1:0] eff_cnt;

  // sequencer state
  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic              wrapped_q, wrapped_d;
  logic [CNT_W-1:0]  probes_q, probes_d;
  logic [SLOTS-1:0]  used_q, used_d;

  // pending result
  logic              res_valid_q, res_valid_d;
  logic [IDX_W-1:0]  res_slot_q, res_slot_d;
  logic              res_new_q, res_new_d;

  // output register
  logic              m_valid_q, m_valid_d;
  logic [IDX_W-1:0]  m_slot_q, m_slot_d;
  logic              m_sv_q, m_sv_d;
  logic              m_new_q, m_new_d;

  // key table, registered read
  logic [KEY_W-1:0]  key_mem [SLOTS];
  logic [KEY_W-1:0]  rd_key_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_issue;
  logic              mem_we;

  logic              in_acc;
  logic              id_reject;
  logic              match;
  logic [PTR_W-1:0]  ptr_inc;
  logic [PTR_W-1:0]  base_ptr;
  logic              out_free;

  function automatic logic in_range(logic [PTR_W-1:0] p, logic b, logic [CFG_W-1:0] c);
    logic signed [PTR_W-1:0] ps;
    logic signed [PTR_W-1:0] bs;
    logic signed [PTR_W-1:0] cs;
    ps = $signed(p);
    bs = $signed({{(PTR_W-1){1'b0}}, b});
    cs = $signed({{(PTR_W-CFG_W){1'b0}}, c});
    return (ps >= bs) && (ps < cs);
  endfunction

  assign eff_cnt  = (slot_count_q > COUNT_MAX) ? COUNT_MAX : slot_count_q;
  assign base_ptr = {{(PTR_W-1){1'b0}}, slot_base_q};
  assign ptr_inc  = ptr_q + PTR_W'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // negative ids, and zero when base is one
  assign id_reject = s_axis_tdata[IN_DATA_W-1] ||
                     (slot_base_q && (s_axis_tdata == '0));

  assign match    = rd_vld_q && used_q[rd_idx_q] && (rd_key_q == key_q);
  assign rd_issue = (state_q == ST_SCAN) && (scan_q < CNT_W'(SLOTS));
  assign rd_vld_d = rd_issue;
  assign mem_we   = (state_q == ST_WRITE);
  assign out_free = !m_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    key_d       = key_q;
    scan_d      = scan_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    ptr_d       = ptr_q;
    wrapped_d   = wrapped_q;
    probes_d    = probes_q;
    used_d      = used_q;
    res_valid_d = res_valid_q;
    res_slot_d  = res_slot_q;
    res_new_d   = res_new_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d       = req_e'(s_axis_tuser);
          key_d       = s_axis_tdata[KEY_W-1:0];
          scan_d      = '0;
          hit_d       = 1'b0;
          res_valid_d = 1'b0;
          res_slot_d  = '0;
          res_new_d   = 1'b0;
          if (id_reject || (req_e'(s_axis_tuser) == REQ_NONE)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      // one table entry per cycle, stop at the first live match
      ST_SCAN: begin
        if (rd_issue) begin
          scan_d = scan_q + CNT_W'(1);
        end
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx_q;
          state_d   = ST_DECIDE;
        end else if (rd_vld_q && (rd_idx_q == IDX_W'(SLOTS - 1))) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_d = ST_DONE;
        unique case (req_q)
          REQ_ASSIGN: begin
            if (eff_cnt != '0) begin
              if (hit_q) begin
                res_valid_d = 1'b1;
                res_slot_d  = hit_idx_q;
              end else if (eff_cnt > CFG_W'(slot_base_q)) begin
                state_d = ST_ALLOC;
              end
            end
          end
          REQ_LOOKUP: begin
            if ((eff_cnt != '0) && hit_q) begin
              res_valid_d = 1'b1;
              res_slot_d  = hit_idx_q;
            end
          end
          REQ_DELETE: begin
            if (hit_q) begin
              used_d[hit_idx_q] = 1'b0;
              res_valid_d       = 1'b1;
              res_slot_d        = hit_idx_q;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // first pointer step: rising order until the pointer runs past the top
      ST_ALLOC: begin
        probes_d = '0;
        if (!in_range(ptr_inc, slot_base_q, eff_cnt)) begin
          wrapped_d = 1'b1;
          ptr_d     = base_ptr;
          state_d   = ST_PROBE;
        end else begin
          ptr_d = ptr_inc;
          if (!wrapped_q) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_PROBE;
          end
        end
      end

      // one probe per cycle, at most count probes
      ST_PROBE: begin
        if (probes_q == CNT_W'(eff_cnt)) begin
          state_d = ST_DONE;
        end else begin
          probes_d = probes_q + CNT_W'(1);
          if (in_range(ptr_q, slot_base_q, eff_cnt) && !used_q[ptr_q[IDX_W-1:0]]) begin
            state_d = ST_WRITE;
          end else if (!in_range(ptr_inc, slot_base_q, eff_cnt)) begin
            // wrap to base, take it if free, else step past it
            if (in_range(base_ptr, slot_base_q, eff_cnt) &&
                !used_q[base_ptr[IDX_W-1:0]]) begin
              ptr_d   = base_ptr;
              state_d = ST_WRITE;
            end else begin
              ptr_d = base_ptr + PTR_W'(1);
            end
          end else begin
            ptr_d = ptr_inc;
          end
        end
      end

      ST_WRITE: begin
        used_d[ptr_q[IDX_W-1:0]] = 1'b1;
        res_valid_d              = 1'b1;
        res_slot_d               = ptr_q[IDX_W-1:0];
        res_new_d                = 1'b1;
        state_d                  = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register write clears the bindings
    if (cfg_we_i) begin
      used_d    = '0;
      wrapped_d = 1'b0;
      if (cfg_reg_e'(cfg_idx_i) == REG_SLOT_BASE) begin
        ptr_d = {{(PTR_W-1){1'b0}}, cfg_data_i[0]} - PTR_W'(1);
      end else begin
        ptr_d = base_ptr - PTR_W'(1);
      end
    end
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_slot_d  = m_slot_q;
    m_sv_d    = m_sv_q;
    m_new_d   = m_new_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if ((state_q == ST_DONE) && out_free) begin
      m_valid_d = 1'b1;
      m_slot_d  = res_valid_q ? res_slot_q : '0;
      m_sv_d    = res_valid_q;
      m_new_d   = res_new_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(m_slot_q);
  assign m_axis_tuser  = {m_new_q, m_sv_q};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_count_q <= '0;
      slot_base_q  <= 1'b0;
      ptr_q        <= '1;
      wrapped_q    <= 1'b0;
      used_q       <= '0;
      scan_q       <= '0;
      probes_q     <= '0;
      hit_q        <= 1'b0;
      rd_vld_q     <= 1'b0;
      res_valid_q  <= 1'b0;
      res_new_q    <= 1'b0;
      m_valid_q    <= 1'b0;
      m_sv_q       <= 1'b0;
      m_new_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      wrapped_q   <= wrapped_d;
      used_q      <= used_d;
      scan_q      <= scan_d;
      probes_q    <= probes_d;
      hit_q       <= hit_d;
      rd_vld_q    <= rd_vld_d;
      res_valid_q <= res_valid_d;
      res_new_q   <= res_new_d;
      m_valid_q   <= m_valid_d;
      m_sv_q      <= m_sv_d;
      m_new_q     <= m_new_d;
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_idx_i) == REG_SLOT_BASE) begin
          slot_base_q <= cfg_data_i[0];
        end else begin
          slot_count_q <= cfg_data_i;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    hit_idx_q  <= hit_idx_d;
    res_slot_q <= res_slot_d;
    m_slot_q   <= m_slot_d;
    rd_idx_q   <= scan_q[IDX_W-1:0];
  end

  // key table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[ptr_q[IDX_W-1:0]] <= key_q;
    end
    rd_key_q <= key_mem[scan_q[IDX_W-1:0]];
  end

  // checks
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |->
      (in_range(ptr_q, slot_base_q, eff_cnt) && !used_q[ptr_q[IDX_W-1:0]]))
    else $error("allocated slot is busy or out of range");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (probes_q <= CNT_W'(eff_cnt)))
    else $error("probe count ran past slot count");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (used_q == '0) && !wrapped_q)
    else $error("config write left bindings behind");

  a_new_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_new_q) |-> m_sv_q)
    else $error("new binding reported without a slot");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_sv_q) |-> (m_slot_q == '0))
    else $error("slot number nonzero without a slot");

endmodule
